// ===== hdl/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// mac_pkg: shared types and constants
// Sample format and configuration register map of the moving-average filter.
// ----------------------------------------------------------------------------
package mac_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int TAP_W     = 7;
	localparam int CFG_AW    = 4;
	localparam int REG_IDX_W = 2;

	localparam logic [REG_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TAP_COUNT     = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CENTER_WEIGHT = 2'd2;

	localparam logic [TAP_W-1:0] TAP_RESET = 7'd1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== hdl/moving_average_center_weight.sv =====
// ----------------------------------------------------------------------------
// moving_average_center_weight: moving-average filter with center weighting
// Sample history in a circular RAM; window summed one tap per cycle, then
// divided by the tap count (plus one with center weighting).
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = sample_in
//  m_*       out  m_tvalid/m_tready  m_tdata = sample_out
//  apb       in   psel/penable/...   regs at 0x0, 0x4, 0x8
//
//  Filter on: the n taps are read one per cycle from the history RAM, then the
//  divider produces one quotient bit per cycle (SW = 23 bits for 64 taps).
//  Filter off: the sample skips the sum and divide. One sample in flight;
//  the output register lets the next sample start while a result waits.
//  Reset: no clearing pass; a fill count makes unwritten history read as zero.
// ----------------------------------------------------------------------------
module moving_average_center_weight
	import mac_pkg::*;
#(
	parameter int MAX_TAPS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	// stream in
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
	// stream out
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
	// config
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int AW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(MAX_TAPS + 1);
	localparam int DW    = $clog2(MAX_TAPS + 2);
	localparam int SW    = SAMPLE_W + DW;
	localparam int EW    = ((TAP_W > NW) ? TAP_W : NW) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// config registers
	logic             enable_q;
	logic [TAP_W-1:0] tap_q;
	logic             cw_q;

	logic             cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[CFG_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			tap_q    <= TAP_RESET;
			cw_q     <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_FILTER_ENABLE: enable_q <= pwdata[0];
				REG_TAP_COUNT:     tap_q    <= pwdata[TAP_W-1:0];
				REG_CENTER_WEIGHT: cw_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FILTER_ENABLE: prdata = 32'(enable_q);
			REG_TAP_COUNT:     prdata = 32'(tap_q);
			REG_CENTER_WEIGHT: prdata = 32'(cw_q);
			default:           prdata = '0;
		endcase
	end

	// effective tap count, clamped to 1..MAX_TAPS
	logic [EW-1:0] tap_ext;
	logic [NW-1:0] n_eff;

	assign tap_ext = EW'(tap_q);

	always_comb begin
		if (tap_ext == '0) begin
			n_eff = NW'(1);
		end else if (tap_ext > EW'(MAX_TAPS)) begin
			n_eff = NW'(MAX_TAPS);
		end else begin
			n_eff = NW'(tap_ext);
		end
	end

	// control state
	logic [1:0]    state_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] newest_q;
	logic [NW-1:0] fill_q;
	logic [NW-1:0] rd_j_q;
	logic [NW-1:0] n_q;
	logic [NW-1:0] n_last_q;
	logic [NW-1:0] mid_q;
	logic [DW-1:0] div_q;
	logic          dbl_q;
	logic          rv_s1;
	logic [NW-1:0] rj_s1;
	logic          m_tvalid_q;

	logic signed [SW-1:0] acc_q;
	sample_t              result_q;
	sample_t              m_tdata_q;

	logic                 in_beat;
	logic                 issue;
	logic                 last_beat;
	logic                 out_free;
	logic [SAMPLE_W-1:0]  rdata;
	logic signed [SW-1:0] tap_val;
	logic signed [SW-1:0] term;
	logic signed [SW-1:0] acc_nxt;
	logic                 div_done;
	logic signed [SW-1:0] div_quo;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign issue     = (state_q == ST_SUM) && (rd_j_q != n_q);
	assign last_beat = rv_s1 && (rj_s1 == n_last_q);
	assign out_free  = !m_tvalid_q || m_tready;

	// taps older than the number of samples ever written read as zero
	assign tap_val = (rj_s1 < fill_q) ? SW'(signed'(rdata)) : '0;
	assign term    = (dbl_q && (rj_s1 == mid_q)) ? tap_val + tap_val : tap_val;
	assign acc_nxt = acc_q + term;

	mac_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (in_beat),
		.waddr (wp_q),
		.wdata (s_tdata),
		.raddr (newest_q - AW'(rd_j_q)),
		.rdata (rdata)
	);

	mac_div #(
		.NUM_W(SW),
		.DEN_W(DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (last_beat),
		.num    (acc_nxt),
		.den    (div_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			newest_q   <= '0;
			fill_q     <= '0;
			rd_j_q     <= '0;
			rv_s1      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rv_s1 <= issue;
			if (issue) begin
				rd_j_q <= rd_j_q + 1'b1;
			end
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						wp_q     <= wp_q + 1'b1;
						newest_q <= wp_q;
						rd_j_q   <= '0;
						if (fill_q != NW'(MAX_TAPS)) begin
							fill_q <= fill_q + 1'b1;
						end
						state_q <= enable_q ? ST_SUM : ST_FIN;
					end
				end
				ST_SUM: begin
					if (last_beat) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rj_s1 <= rd_j_q;
		if (in_beat) begin
			n_q      <= n_eff;
			n_last_q <= n_eff - 1'b1;
			mid_q    <= n_eff >> 1;
			dbl_q    <= cw_q;
			div_q    <= cw_q ? DW'(n_eff) + 1'b1 : DW'(n_eff);
			acc_q    <= '0;
			result_q <= s_tdata;
		end else if (rv_s1) begin
			acc_q <= acc_nxt;
		end
		if (div_done) begin
			result_q <= div_quo[SAMPLE_W-1:0];
		end
		if (state_q == ST_FIN && out_free) begin
			m_tdata_q <= result_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== hdl/mac_ram.sv =====
// ----------------------------------------------------------------------------
// mac_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module mac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/mac_div.sv =====
// ----------------------------------------------------------------------------
// mac_div: signed by unsigned restoring divider
// One quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module mac_div #(
	parameter int NUM_W = 23,
	parameter int DEN_W = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo
);

	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] work_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]   shifted;
	logic             ge;

	assign shifted = {rem_q[DEN_W-1:0], work_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q  <= num[NUM_W-1];
			work_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= ge ? shifted - {1'b0, den_q} : shifted;
			work_q <= {work_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? -signed'(work_q) : signed'(work_q);

endmodule

// ===== hdl/mac_chk.sv =====
// ----------------------------------------------------------------------------
// mac_chk: port-level checks for the moving-average filter
// Tracks samples in flight and checks input and output behavior over time.
// ----------------------------------------------------------------------------
module mac_chk
	import mac_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [SAMPLE_W-1:0] m_tdata
);

	logic [1:0] pend_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_beat && !out_beat) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> !s_tready)
		else $error("input ready right after an accepted beat");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("output beat without a sample in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> pend_q <= 2'd1)
		else $error("input ready with two samples in flight");

endmodule

bind moving_average_center_weight mac_chk u_mac_chk (.*);
